FILE: rtl/assert_macros.svh
// Assertion macros shared by the RTL files of the calendar converter.
// Needs a clock named clk_i and an active-low reset named rst_ni in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, disabled while reset is asserted.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Clocked check that also holds during reset.
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

FILE: rtl/usc_pkg.sv
// Types, constants and helper functions of the calendar converter.
// No dependencies; used by usc_ctrl, usc_datapath and the top level.
package usc_pkg;

  localparam int unsigned DaySecs     = 86400;
  localparam int unsigned SecsPerMin  = 60;
  // ceil(2^35 / 675): seconds >> 7 times this, >> 35, gives whole days
  localparam logic [25:0] DayRecip    = 26'd50903317;
  // ceil(2^18 / 15): value >> 2 times this, >> 18, gives value / 60
  localparam logic [14:0] SixtyRecip  = 15'd17477;
  localparam logic [7:0]  NoLeapCent  = 8'd130;
  localparam logic [2:0]  EpochWday   = 3'd4;
  localparam logic [3:0]  LastMonth   = 4'd11;

  typedef enum logic [1:0] {
    PH_DAY  = 2'd0,
    PH_MIN  = 2'd1,
    PH_HOUR = 2'd2,
    PH_CAL  = 2'd3
  } phase_e;

  typedef struct packed {
    logic   load;
    phase_e phase;
    logic   div_step;
    logic   year_step;
    logic   month_step;
    logic   finish;
  } cmd_t;

  typedef struct packed {
    logic year_done;
    logic month_done;
  } status_t;

  // Year offsets 0..136 from 1970: leap when offset+2 is a multiple of 4,
  // except the year 2100.
  function automatic logic is_leap(input logic [7:0] off);
    return (off[1:0] == 2'b10) && (off != NoLeapCent);
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] month, input logic leap);
    logic [4:0] len;
    case (month)
      4'd0, 4'd2, 4'd4, 4'd6, 4'd7, 4'd9, 4'd11: len = 5'd31;
      4'd3, 4'd5, 4'd8, 4'd10:                    len = 5'd30;
      4'd1:                                       len = leap ? 5'd29 : 5'd28;
      default:                                    len = 5'd31;
    endcase
    return len;
  endfunction

  function automatic logic [2:0] add_mod7(input logic [2:0] a, input logic [2:0] b);
    logic [3:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= 4'd7) begin
      s = s - 4'd7;
    end
    return s[2:0];
  endfunction

  function automatic logic [2:0] mod7_small(input logic [4:0] v);
    logic [4:0] r;
    r = v;
    for (int i = 0; i < 4; i++) begin
      if (r >= 5'd7) begin
        r = r - 5'd7;
      end
    end
    return r[2:0];
  endfunction

endpackage

FILE: rtl/usc_datapath.sv
// Datapath of the calendar converter: reciprocal dividers for days, minutes
// and hours, year and month subtract loops, weekday accumulator. Depends on usc_pkg.
module usc_datapath (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  usc_pkg::cmd_t    cmd_i,
  input  logic [31:0]      unix_seconds_i,
  output usc_pkg::status_t status_o,
  output logic [5:0]       seconds_o,
  output logic [5:0]       minutes_o,
  output logic [4:0]       hours_o,
  output logic [2:0]       weekday_o,
  output logic [7:0]       year_offset_o,
  output logic [3:0]       month_number_o,
  output logic [4:0]       day_of_month_o
);
  import usc_pkg::*;

  logic [31:0] num_q, num_d;
  logic [15:0] quo_q, quo_d;
  logic [15:0] days_q, days_d;
  logic [5:0]  sec_q, sec_d, min_q, min_d;
  logic [4:0]  hour_q, hour_d;
  logic [7:0]  year_q, year_d;
  logic [3:0]  month_q, month_d;
  logic [2:0]  wd_q, wd_d;
  logic [2:0]  wday_q, wday_d;
  logic [4:0]  dom_q, dom_d;

  logic [50:0] day_prod;
  logic [29:0] sixty_prod;
  logic [31:0] day_base;
  logic [16:0] sixty_base;
  logic [16:0] sixty_rem;
  logic        leap;
  logic [8:0]  year_len;
  logic [4:0]  mlen;

  assign day_prod   = 51'(num_q[31:7]) * 51'(DayRecip);
  assign sixty_prod = 30'(num_q[16:2]) * 30'(SixtyRecip);
  assign day_base   = 32'(quo_q) * 32'(DaySecs);
  assign sixty_base = 17'(quo_q) * 17'(SecsPerMin);
  assign sixty_rem  = num_q[16:0] - sixty_base;
  assign leap       = is_leap(year_q);
  assign year_len   = leap ? 9'd366 : 9'd365;
  assign mlen       = month_len(month_q, leap);

  assign status_o.year_done  = days_q < {7'd0, year_len};
  assign status_o.month_done = (days_q < {11'd0, mlen}) || (month_q == LastMonth);

  always_comb begin
    num_d   = num_q;
    quo_d   = quo_q;
    days_d  = days_q;
    sec_d   = sec_q;
    min_d   = min_q;
    hour_d  = hour_q;
    year_d  = year_q;
    month_d = month_q;
    wd_d    = wd_q;
    wday_d  = wday_q;
    dom_d   = dom_q;
    if (cmd_i.load) begin
      case (cmd_i.phase)
        PH_DAY: begin
          num_d = unix_seconds_i;
        end
        PH_MIN: begin
          days_d = quo_q;
          num_d  = num_q - day_base;
        end
        PH_HOUR: begin
          sec_d = sixty_rem[5:0];
          num_d = {16'd0, quo_q};
        end
        PH_CAL: begin
          min_d   = sixty_rem[5:0];
          hour_d  = quo_q[4:0];
          year_d  = '0;
          month_d = '0;
          wd_d    = EpochWday;
        end
        default: begin
          num_d = num_q;
        end
      endcase
    end
    if (cmd_i.div_step) begin
      case (cmd_i.phase)
        PH_DAY: begin
          quo_d = day_prod[50:35];
        end
        default: begin
          quo_d = {5'd0, sixty_prod[28:18]};
        end
      endcase
    end
    if (cmd_i.year_step) begin
      days_d = days_q - {7'd0, year_len};
      year_d = year_q + 8'd1;
      wd_d   = add_mod7(wd_q, leap ? 3'd2 : 3'd1);
    end
    if (cmd_i.month_step) begin
      days_d  = days_q - {11'd0, mlen};
      month_d = month_q + 4'd1;
      wd_d    = add_mod7(wd_q, 3'(mlen - 5'd28));
    end
    if (cmd_i.finish) begin
      dom_d  = days_q[4:0] + 5'd1;
      wday_d = add_mod7(wd_q, mod7_small(days_q[4:0])) + 3'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q   <= num_d;
    quo_q   <= quo_d;
    days_q  <= days_d;
    sec_q   <= sec_d;
    min_q   <= min_d;
    hour_q  <= hour_d;
    year_q  <= year_d;
    month_q <= month_d;
    wd_q    <= wd_d;
    wday_q  <= wday_d;
    dom_q   <= dom_d;
  end

  assign seconds_o      = sec_q;
  assign minutes_o      = min_q;
  assign hours_o        = hour_q;
  assign weekday_o      = wday_q;
  assign year_offset_o  = year_q;
  assign month_number_o = month_q + 4'd1;
  assign day_of_month_o = dom_q;

  `include "assert_macros.svh"

  `ASSERT_CLK(a_sod_range, cmd_i.load && cmd_i.phase == PH_MIN |=> num_q < DaySecs, "sod too large")
  `ASSERT_CLK(a_year_step_fits, cmd_i.year_step |-> !status_o.year_done, "year step past end")
  `ASSERT_CLK(a_dom_range, $past(cmd_i.finish) |-> (dom_q != 5'd0), "day of month is zero")

endmodule

FILE: rtl/usc_ctrl.sv
// Controller of the calendar converter: sequences divider phases, year and
// month loops, and the result strobe. Depends on usc_pkg.
module usc_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  output logic             done_o,
  input  usc_pkg::status_t status_i,
  output usc_pkg::cmd_t    cmd_o
);
  import usc_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_DIV   = 6'b000010,
    ST_LOAD  = 6'b000100,
    ST_YEAR  = 6'b001000,
    ST_MONTH = 6'b010000,
    ST_DONE  = 6'b100000
  } state_e;

  state_e            state_q, state_d;
  phase_e            phase_q, phase_d;

  always_comb begin
    state_d = state_q;
    phase_d = phase_q;
    cmd_o   = '0;
    cmd_o.phase = phase_q;
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          cmd_o.load  = 1'b1;
          cmd_o.phase = PH_DAY;
          phase_d     = PH_DAY;
          state_d     = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        state_d        = ST_LOAD;
        case (phase_q)
          PH_DAY:  phase_d = PH_MIN;
          PH_MIN:  phase_d = PH_HOUR;
          default: phase_d = PH_CAL;
        endcase
      end
      ST_LOAD: begin
        cmd_o.load = 1'b1;
        case (phase_q)
          PH_MIN: begin
            state_d = ST_DIV;
          end
          PH_HOUR: begin
            state_d = ST_DIV;
          end
          default: begin
            state_d = ST_YEAR;
          end
        endcase
      end
      ST_YEAR: begin
        if (status_i.year_done) begin
          state_d = ST_MONTH;
        end else begin
          cmd_o.year_step = 1'b1;
        end
      end
      ST_MONTH: begin
        if (status_i.month_done) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_DONE;
        end else begin
          cmd_o.month_step = 1'b1;
        end
      end
      ST_DONE: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      phase_q <= PH_DAY;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
    end
  end

  assign busy   = state_q != ST_IDLE;
  assign done_o = state_q == ST_DONE;

  `include "assert_macros.svh"

  `ASSERT_CLK(a_start_to_div, (start && !busy) |=> (state_q == ST_DIV), "accept did not start divide")
  `ASSERT_CLK(a_done_from_month, done_o |-> ($past(state_q) == ST_MONTH), "strobe without month loop")
  `ASSERT_CLK(a_done_one_cycle, done_o |=> !busy, "result strobe longer than one cycle")
  `ASSERT_CLK(a_div_end_load, (state_q == ST_DIV) |=> (state_q == ST_LOAD), "divide overrun")

endmodule

FILE: rtl/unix_seconds_to_calendar.sv
// Top level of the Unix seconds to calendar converter.
// Instantiates usc_ctrl and usc_datapath; depends on usc_pkg.
//
// A transaction is taken when start is high and busy is low. The result is
// shown for exactly one cycle with done_o high; it cannot be held off, so
// capture it in that cycle. The strobe follows the divide and load steps,
// the year loop over the year offset Y (0..136) and the month loop over the
// month index M (0..11); Y + M peaks at 146 late in 2105. The time of day
// comes from reciprocal multiplications, each quotient followed by its
// remainder; the date comes from one year and then one month subtracted per
// cycle. busy stays high until the strobe cycle has passed.
module unix_seconds_to_calendar (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] unix_seconds_i,
  output logic        done_o,
  output logic [5:0]  seconds_o,
  output logic [5:0]  minutes_o,
  output logic [4:0]  hours_o,
  output logic [2:0]  weekday_o,
  output logic [7:0]  year_offset_o,
  output logic [3:0]  month_number_o,
  output logic [4:0]  day_of_month_o
);
  import usc_pkg::*;

  cmd_t    cmd;
  status_t status;

  usc_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .done_o   (done_o),
    .status_i (status),
    .cmd_o    (cmd)
  );

  usc_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .unix_seconds_i (unix_seconds_i),
    .status_o       (status),
    .seconds_o      (seconds_o),
    .minutes_o      (minutes_o),
    .hours_o        (hours_o),
    .weekday_o      (weekday_o),
    .year_offset_o  (year_offset_o),
    .month_number_o (month_number_o),
    .day_of_month_o (day_of_month_o)
  );

endmodule
